FILE: design/drrip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared types, constants and the LFSR helper function of the DRRIP replacement core.
// ----------------------------------------------------------------------------
package drrip_pkg;

    // Default geometry of the cache that the core serves.
    localparam int NUM_SETS_DEF           = 2048;
    localparam int NUM_WAYS_DEF           = 16;
    localparam int LEADERS_PER_POLICY_DEF = 64;
    localparam int SELECTOR_BITS_DEF      = 10;

    // Fixed field widths of the transaction ports.
    localparam int SET_IDX_W = 11;
    localparam int WAY_IDX_W = 4;
    localparam int NIBBLE_W  = 4;
    localparam int RRPV_W    = 2;
    localparam int LFSR_W    = 16;
    localparam int BIMODAL_W = 4;

    // Per-line history word: last nibble on top of the two newest deltas.
    localparam int HIST_W      = 2 * NIBBLE_W;
    localparam int LINE_DATA_W = NIBBLE_W + HIST_W;

    // Operation codes.
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Re-reference values.
    localparam logic [RRPV_W-1:0] RRPV_HIT    = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_INSERT = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_MAX    = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_RESET  = 2'd2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'd1;

    // Configuration port.
    localparam int                    APB_DATA_W        = 32;
    localparam int                    PADDR_W           = 3;
    localparam logic                  REG_BIMODAL_LOG2  = 1'b0;
    localparam logic [BIMODAL_W-1:0]  BIMODAL_LOG2_RST  = 4'd5;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic addr_from_port;
        logic capture;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_query;
        logic out_blocked;
    } dp_status_t;

    // Fibonacci LFSR, taps 16, 14, 13 and 11, shifting right.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage
`default_nettype wire

FILE: design/drrip_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module drrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/drrip_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_ctrl
// Controller: clearing pass after reset, then accept and execute one
// transaction at a time.
// ----------------------------------------------------------------------------
module drrip_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire drrip_pkg::dp_status_t  status,
    output drrip_pkg::dp_cmd_t          cmd
);

    import drrip_pkg::*;

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next         = state_reg;
        s_ready            = 1'b0;
        cmd.clear_en       = 1'b0;
        cmd.addr_from_port = 1'b0;
        cmd.capture        = 1'b0;
        cmd.commit         = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready            = 1'b1;
                cmd.addr_from_port = 1'b1;
                cmd.capture        = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // A query waits while the previous result is still pending.
                cmd.commit = !(status.is_query && status.out_blocked);
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted transaction enters execute in the following cycle.
    a_capture_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not move to execute");

    // After a commit the controller is ready again.
    a_commit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_ready)
        else $error("controller not ready after commit");

    // A query never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && status.is_query) |-> !status.out_blocked)
        else $error("query committed over a pending result");

    // Memory writes of the clearing pass and of a transaction never overlap.
    a_clear_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_en |-> !(cmd.commit || cmd.capture || s_ready))
        else $error("transaction activity during clearing pass");
`endif

endmodule
`default_nettype wire

FILE: design/drrip_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_datapath
// Set-row and line memories, victim search with aging, streaming detector,
// set dueling selector, LFSR and the result register.
// ----------------------------------------------------------------------------
module drrip_datapath #(
    parameter int NUM_SETS           = drrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS           = drrip_pkg::NUM_WAYS_DEF,
    parameter int LEADERS_PER_POLICY = drrip_pkg::LEADERS_PER_POLICY_DEF,
    parameter int SELECTOR_BITS      = drrip_pkg::SELECTOR_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_op,
    input  wire logic [drrip_pkg::SET_IDX_W-1:0]     s_set_index,
    input  wire logic [drrip_pkg::WAY_IDX_W-1:0]     s_way_index,
    input  wire logic                                s_is_hit,
    input  wire logic [drrip_pkg::NIBBLE_W-1:0]      s_addr_nibble,
    input  wire logic [drrip_pkg::BIMODAL_W-1:0]     bimodal_log2,
    input  wire drrip_pkg::dp_cmd_t                  cmd,
    output drrip_pkg::dp_status_t                    status,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [drrip_pkg::WAY_IDX_W-1:0]     m_victim_way
);

    import drrip_pkg::*;

    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int LINE_W     = SET_W + WAY_W;
    localparam int LINE_DEPTH = NUM_SETS * (2 ** WAY_W);
    localparam int ROW_W      = RRPV_W * NUM_WAYS;
    localparam int WRAP_W     = SET_W + 3;

    localparam logic [WRAP_W-1:0] SET_X4 = WRAP_W'(4 * NUM_SETS);
    localparam logic [WRAP_W-1:0] SET_X2 = WRAP_W'(2 * NUM_SETS);
    localparam logic [WRAP_W-1:0] SET_X1 = WRAP_W'(NUM_SETS);

    localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
    localparam logic [SELECTOR_BITS-1:0] SEL_MIN = '0;

    localparam logic [ROW_W-1:0]  ROW_RESET  = {NUM_WAYS{RRPV_RESET}};
    localparam logic [LINE_W-1:0] CLEAR_LAST = LINE_W'(LINE_DEPTH - 1);

    // Captured transaction.
    logic                  op_reg;
    logic [SET_W-1:0]      set_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  way_ok_reg;
    logic                  hit_reg;
    logic [NIBBLE_W-1:0]   nib_reg;

    // Persistent state.
    logic [LINE_W-1:0]        clear_cnt_reg;
    logic [LFSR_W-1:0]        lfsr_reg, lfsr_next;
    logic [SELECTOR_BITS-1:0] sel_reg, sel_next;
    logic                     m_valid_reg, m_valid_next;
    logic [WAY_IDX_W-1:0]     m_victim_reg, m_victim_next;

    // Port-side decode.
    logic [WRAP_W-1:0] set_wide;
    logic [SET_W-1:0]  port_set;
    logic [WAY_W-1:0]  port_way;
    logic              port_way_ok;

    // Memory ports.
    logic                   row_we, line_we;
    logic [SET_W-1:0]       row_waddr, row_raddr;
    logic [LINE_W-1:0]      line_waddr, line_raddr;
    logic [ROW_W-1:0]       row_wdata, row_rdata;
    logic [LINE_DATA_W-1:0] line_wdata, line_rdata;

    // Execution results.
    logic [RRPV_W-1:0]      top;
    logic [RRPV_W-1:0]      age_add;
    logic [ROW_W-1:0]       aged_row;
    logic [WAY_IDX_W-1:0]   victim;
    logic [ROW_W-1:0]       upd_row;
    logic [NIBBLE_W-1:0]    last_nib;
    logic [HIST_W-1:0]      hist;
    logic [NIBBLE_W-1:0]    delta;
    logic                   streaming;
    logic [LFSR_W-1:0]      lfsr_stepped;
    logic [LFSR_W-1:0]      bimodal_mask;
    logic                   bimodal_two;
    logic                   srrip_leader, brrip_leader;
    logic [RRPV_W-1:0]      ins;
    logic                   fill;

    // Wrap the set index into range; the index is below eight times the set count.
    always_comb begin
        set_wide = WRAP_W'(s_set_index);
        if (set_wide >= SET_X4) begin
            set_wide = set_wide - SET_X4;
        end
        if (set_wide >= SET_X2) begin
            set_wide = set_wide - SET_X2;
        end
        if (set_wide >= SET_X1) begin
            set_wide = set_wide - SET_X1;
        end
        port_set    = set_wide[SET_W-1:0];
        port_way    = WAY_W'(s_way_index);
        port_way_ok = int'(s_way_index) < NUM_WAYS;
    end

    // Capture the accepted transaction.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_op;
            set_reg    <= port_set;
            way_reg    <= port_way;
            way_ok_reg <= port_way_ok;
            hit_reg    <= s_is_hit;
            nib_reg    <= s_addr_nibble;
        end
    end

    // Read addresses come from the ports while accepting, else from the capture.
    assign row_raddr  = cmd.addr_from_port ? port_set : set_reg;
    assign line_raddr = cmd.addr_from_port ? {port_set, port_way} : {set_reg, way_reg};

    // Victim search: age the row so that its largest value reaches the maximum.
    always_comb begin
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            top[1] = top[1] | row_rdata[RRPV_W*w+1];
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            top[0] = top[0] | ((row_rdata[RRPV_W*w+1] == top[1]) && row_rdata[RRPV_W*w]);
        end
        age_add = RRPV_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged_row[RRPV_W*w +: RRPV_W] = row_rdata[RRPV_W*w +: RRPV_W] + age_add;
        end
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (aged_row[RRPV_W*w +: RRPV_W] == RRPV_MAX) begin
                victim = WAY_IDX_W'(w);
            end
        end
    end

    // Fill: delta history, streaming detection and insertion value.
    always_comb begin
        last_nib = line_rdata[LINE_DATA_W-1:HIST_W];
        hist     = line_rdata[HIST_W-1:0];
        delta    = (nib_reg >= last_nib) ? (nib_reg - last_nib) : (last_nib - nib_reg);
        streaming = (delta == hist[NIBBLE_W-1:0]) &&
                    (hist[NIBBLE_W-1:0] == hist[HIST_W-1:NIBBLE_W]) &&
                    (delta != '0);

        lfsr_stepped = lfsr_step(lfsr_reg);
        for (int i = 0; i < LFSR_W; i++) begin
            bimodal_mask[i] = i < int'(bimodal_log2);
        end
        bimodal_two = (lfsr_stepped & bimodal_mask) == '0;

        srrip_leader = int'(set_reg) < LEADERS_PER_POLICY;
        brrip_leader = !srrip_leader && (int'(set_reg) < 2 * LEADERS_PER_POLICY);

        if (srrip_leader) begin
            ins = RRPV_INSERT;
        end else if (!brrip_leader && sel_reg >= SEL_MID) begin
            ins = RRPV_INSERT;
        end else begin
            ins = bimodal_two ? RRPV_INSERT : RRPV_MAX;
        end
        if (streaming) begin
            ins = RRPV_MAX;
        end

        // Row with the updated way replaced.
        upd_row = row_rdata;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == way_reg) begin
                upd_row[RRPV_W*w +: RRPV_W] = hit_reg ? RRPV_HIT : ins;
            end
        end
    end

    assign fill = cmd.commit && (op_reg == OP_UPDATE) && way_ok_reg && !hit_reg;

    // Memory writes: clearing pass or the commit of a transaction.
    always_comb begin
        if (cmd.clear_en) begin
            row_we     = 1'b1;
            row_waddr  = clear_cnt_reg[LINE_W-1:WAY_W];
            row_wdata  = ROW_RESET;
            line_we    = 1'b1;
            line_waddr = clear_cnt_reg;
            line_wdata = '0;
        end else begin
            row_we     = cmd.commit && ((op_reg == OP_QUERY) || way_ok_reg);
            row_waddr  = set_reg;
            row_wdata  = (op_reg == OP_QUERY) ? aged_row : upd_row;
            line_we    = fill;
            line_waddr = {set_reg, way_reg};
            line_wdata = {nib_reg, hist[NIBBLE_W-1:0], delta};
        end
    end

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    drrip_ram #(
        .WIDTH (LINE_DATA_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Selector and LFSR move only on a fill.
    always_comb begin
        lfsr_next = lfsr_reg;
        sel_next  = sel_reg;
        if (fill) begin
            lfsr_next = lfsr_stepped;
            if (srrip_leader && sel_reg != SEL_MIN) begin
                sel_next = sel_reg - 1'b1;
            end else if (brrip_leader && sel_reg != SEL_MAX) begin
                sel_next = sel_reg + 1'b1;
            end
        end
    end

    // Result register.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_victim_next = m_victim_reg;
        if (cmd.commit && (op_reg == OP_QUERY)) begin
            m_valid_next  = 1'b1;
            m_victim_next = victim;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
            lfsr_reg      <= LFSR_SEED;
            sel_reg       <= SEL_MID;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.clear_en) begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            lfsr_reg    <= lfsr_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_victim_reg <= m_victim_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_victim_way = m_victim_reg;

    assign status.clear_last  = clear_cnt_reg == CLEAR_LAST;
    assign status.is_query    = op_reg == OP_QUERY;
    assign status.out_blocked = m_valid_reg && !m_ready;

endmodule
`default_nettype wire

FILE: design/drrip_streaming_replacement_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_streaming_replacement_core
// DRRIP replacement engine with per-line streaming detection for a set
// associative cache, with a valid/ready transaction interface and an APB port.
// ----------------------------------------------------------------------------
// Each transaction has an accept step, which reads the set row and the line
// history from memory, and an execute state, which computes the result and
// writes both back; a new transaction is accepted only after the previous one
// has committed. A victim query also waits in execute while the previous
// victim is still pending on the result channel. After reset the core clears
// all NUM_SETS * 2**ceil(log2(NUM_WAYS)) line memory entries (32768 with the
// default geometry) with s_ready low; APB writes are taken throughout.
module drrip_streaming_replacement_core #(
    parameter int NUM_SETS           = drrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS           = drrip_pkg::NUM_WAYS_DEF,
    parameter int LEADERS_PER_POLICY = drrip_pkg::LEADERS_PER_POLICY_DEF,
    parameter int SELECTOR_BITS      = drrip_pkg::SELECTOR_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input transactions.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_op,
    input  wire logic [drrip_pkg::SET_IDX_W-1:0]    s_set_index,
    input  wire logic [drrip_pkg::WAY_IDX_W-1:0]    s_way_index,
    input  wire logic                               s_is_hit,
    input  wire logic [drrip_pkg::NIBBLE_W-1:0]     s_addr_nibble,
    // Result transactions.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [drrip_pkg::WAY_IDX_W-1:0]    m_victim_way,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [drrip_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [drrip_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [drrip_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                    pready
);

    import drrip_pkg::*;

    logic [BIMODAL_W-1:0] bimodal_reg;
    logic                 reg_sel;
    dp_cmd_t              cmd;
    dp_status_t           status;

    // Register decode and the bimodal throttle register.
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2] == REG_BIMODAL_LOG2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bimodal_reg <= BIMODAL_LOG2_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            bimodal_reg <= pwdata[BIMODAL_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(bimodal_reg) : '0;

    drrip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    drrip_datapath #(
        .NUM_SETS           (NUM_SETS),
        .NUM_WAYS           (NUM_WAYS),
        .LEADERS_PER_POLICY (LEADERS_PER_POLICY),
        .SELECTOR_BITS      (SELECTOR_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_op          (s_op),
        .s_set_index   (s_set_index),
        .s_way_index   (s_way_index),
        .s_is_hit      (s_is_hit),
        .s_addr_nibble (s_addr_nibble),
        .bimodal_log2  (bimodal_reg),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_victim_way  (m_victim_way)
    );

endmodule
`default_nettype wire
